// ===== rtl/uv_sphere_vertex_generator_assert.svh =====
// Assertion macros for the UV sphere vertex generator.
`ifndef UV_SPHERE_VERTEX_GENERATOR_ASSERT_SVH
`define UV_SPHERE_VERTEX_GENERATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, clocked on clk, off during rst
`define UVS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define UVS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define UVS_ASSERT_IMP(lbl, ante, cons)
`define UVS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/uvs_pkg.sv =====
// Types, constants and tables shared by the UV sphere vertex generator.
`timescale 1ns / 1ps
package uvs_pkg;

  localparam int CNT_W       = 11;
  localparam int MAX_STRIPS  = 1024;
  localparam int DIV_STEPS   = 32;
  localparam int TEX_STEP    = 16;
  localparam int SEG_ANG_STEP  = 32;
  localparam int RING_ANG_STEP = 31;
  localparam int ANGLE_STAGES_DEF = 16;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_SEGS   = 2'd1;
  localparam logic [1:0] REG_RINGS  = 2'd2;

  localparam logic [15:0] RADIUS_RST = 16'd256;
  localparam logic [10:0] SEGS_RST   = 11'd36;
  localparam logic [10:0] RINGS_RST  = 11'd18;

  localparam logic signed [32:0] CORDIC_K = 33'sd652032874;

  typedef struct packed {
    logic [10:0] rem;
    logic [32:0] q;
    logic [16:0] tex;
    logic [32:0] ang;
  } div_lane_t;

  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] a;
  } rot_t;

  typedef struct packed {
    logic        clamped;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic        flip_t;
    logic        flip_p;
  } meta_t;

  // atan(2^-i) in 2^-32 turn
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] r;
    case (i)
      0: r = 32'd536870912;  1: r = 32'd316933406;  2: r = 32'd167458907;
      3: r = 32'd85004756;   4: r = 32'd42667331;   5: r = 32'd21354465;
      6: r = 32'd10679838;   7: r = 32'd5340245;    8: r = 32'd2670163;
      9: r = 32'd1335087;    10: r = 32'd667544;    11: r = 32'd333772;
      12: r = 32'd166886;    13: r = 32'd83443;     14: r = 32'd41722;
      15: r = 32'd20861;     16: r = 32'd10430;     17: r = 32'd5215;
      18: r = 32'd2608;      19: r = 32'd1304;      20: r = 32'd652;
      21: r = 32'd326;       22: r = 32'd163;       23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/uvs_div_cell.sv =====
// One restoring-division cell: one quotient bit per cycle while en is high, with rounding taps.
`timescale 1ns / 1ps
module uvs_div_cell #(
  parameter int STEP     = 1,
  parameter int TEX_AT   = 16,
  parameter int ANG_AT   = 32
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [10:0]           d,
  input  uvs_pkg::div_lane_t    lane_in,
  output uvs_pkg::div_lane_t    lane_out
);

  logic [11:0] r2;
  logic        qb;
  logic [10:0] rem_n;
  logic [32:0] q_n;
  logic        rnd;
  uvs_pkg::div_lane_t nxt;

  always_comb begin
    r2    = {lane_in.rem, 1'b0};
    qb    = (r2 >= {1'b0, d});
    rem_n = qb ? 11'(r2 - {1'b0, d}) : r2[10:0];
    q_n   = {lane_in.q[31:0], qb};
    // round half-up: remainder plus half the divisor reaches the divisor
    rnd   = (({1'b0, rem_n} + {2'b0, d[10:1]}) >= {1'b0, d});
    nxt.rem = rem_n;
    nxt.q   = q_n;
    nxt.tex = (STEP == TEX_AT) ? 17'(q_n[16:0] + 17'(rnd)) : lane_in.tex;
    nxt.ang = (STEP == ANG_AT) ? 33'(q_n + 33'(rnd)) : lane_in.ang;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_out <= nxt;
    end
  end

endmodule

// ===== rtl/uvs_cordic_cell.sv =====
// One rotation-mode CORDIC cell.
`timescale 1ns / 1ps
module uvs_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic          clk,
  input  logic          en,
  input  uvs_pkg::rot_t rot_in,
  output uvs_pkg::rot_t rot_out
);

  localparam logic signed [32:0] ATAN = $signed({1'b0, uvs_pkg::atan_turn(STAGE)});

  logic signed [32:0] x, y, a, dx, dy;
  uvs_pkg::rot_t nxt;

  always_comb begin
    x  = rot_in.x;
    y  = rot_in.y;
    a  = rot_in.a;
    dx = y >>> STAGE;
    dy = x >>> STAGE;
    if (!a[32]) begin
      nxt.x = x - dx;
      nxt.y = y + dy;
      nxt.a = a - ATAN;
    end else begin
      nxt.x = x + dx;
      nxt.y = y - dy;
      nxt.a = a + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_out <= nxt;
    end
  end

endmodule

// ===== rtl/uv_sphere_vertex_generator.sv =====
// Top level of the UV sphere vertex generator.
`timescale 1ns / 1ps
// Takes a (ring, segment) grid point and returns position, unit normal and
// texture coordinates of that vertex. Fully pipelined: one request per cycle
// while the skid register is empty, through 32 division cells, one fold
// stage, ANGLE_STAGES CORDIC cells, three multiply/round stages and the
// output register. The division chain sets the depth: both angles and both
// texture coordinates come out of one restoring divider per axis, one
// quotient bit per cell. A skid register behind the output keeps tready
// registered; tready drops only when the skid holds a result. Counts of zero
// act as one, counts above 1024 as 1024; an index above its count is clamped
// and flagged in tuser. Write configuration only while the block is idle.
`include "uv_sphere_vertex_generator_assert.svh"
module uv_sphere_vertex_generator #(
  parameter int ANGLE_STAGES = uvs_pkg::ANGLE_STAGES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,   // ring_index[10:0], segment_index[21:11]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x[16:0], pos_y[33:17], pos_z[50:34], norm_x[66:51], norm_y[82:67],
  // norm_z[98:83], tex_u[115:99], tex_v[132:116]
  output logic [135:0] m_axis_tdata,
  output logic         m_axis_tuser,   // index_clamped
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  localparam int NS = uvs_pkg::DIV_STEPS;

  // ---------------- configuration ----------------
  logic [15:0] radius;
  logic [10:0] segs_reg, rings_reg;
  logic [10:0] segs, rings;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius    <= uvs_pkg::RADIUS_RST;
      segs_reg  <= uvs_pkg::SEGS_RST;
      rings_reg <= uvs_pkg::RINGS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        uvs_pkg::REG_RADIUS: radius    <= cfg_data;
        uvs_pkg::REG_SEGS:   segs_reg  <= cfg_data[10:0];
        uvs_pkg::REG_RINGS:  rings_reg <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // effective counts: zero acts as one, large counts capped
  always_comb begin
    segs  = (segs_reg == 11'd0) ? 11'd1 :
            (int'(segs_reg) > uvs_pkg::MAX_STRIPS) ? 11'(uvs_pkg::MAX_STRIPS) : segs_reg;
    rings = (rings_reg == 11'd0) ? 11'd1 :
            (int'(rings_reg) > uvs_pkg::MAX_STRIPS) ? 11'(uvs_pkg::MAX_STRIPS) : rings_reg;
  end

  // ---------------- flow control ----------------
  logic en;
  logic skid_valid;
  assign en = !skid_valid;
  assign s_axis_tready = en;

  // ---------------- clamp and divider seed ----------------
  logic [10:0] ring_in, seg_in, ring_c, seg_c;
  logic        clamp_in, seg_int, ring_int;
  uvs_pkg::div_lane_t seg_lane [0:NS];
  uvs_pkg::div_lane_t ring_lane [0:NS];
  logic        dv [0:NS];
  logic        dcl [0:NS];

  always_comb begin
    ring_in  = s_axis_tdata[10:0];
    seg_in   = s_axis_tdata[21:11];
    clamp_in = (ring_in > rings) || (seg_in > segs);
    ring_c   = (ring_in > rings) ? rings : ring_in;
    seg_c    = (seg_in > segs) ? segs : seg_in;
    seg_int  = (seg_c == segs);
    ring_int = (ring_c == rings);
    seg_lane[0].rem  = seg_int ? 11'd0 : seg_c;
    seg_lane[0].q    = {32'd0, seg_int};
    seg_lane[0].tex  = 17'd0;
    seg_lane[0].ang  = 33'd0;
    ring_lane[0].rem = ring_int ? 11'd0 : ring_c;
    ring_lane[0].q   = {32'd0, ring_int};
    ring_lane[0].tex = 17'd0;
    ring_lane[0].ang = 33'd0;
  end

  assign dv[0]  = s_axis_tvalid;
  assign dcl[0] = clamp_in;

  // ---------------- division chain ----------------
  genvar gi;
  generate
    for (gi = 1; gi <= NS; gi++) begin : g_div
      uvs_div_cell #(.STEP(gi), .TEX_AT(uvs_pkg::TEX_STEP),
                     .ANG_AT(uvs_pkg::SEG_ANG_STEP)) u_seg (
        .clk(clk), .en(en), .d(segs),
        .lane_in(seg_lane[gi-1]), .lane_out(seg_lane[gi])
      );
      uvs_div_cell #(.STEP(gi), .TEX_AT(uvs_pkg::TEX_STEP),
                     .ANG_AT(uvs_pkg::RING_ANG_STEP)) u_ring (
        .clk(clk), .en(en), .d(rings),
        .lane_in(ring_lane[gi-1]), .lane_out(ring_lane[gi])
      );
      always_ff @(posedge clk) begin
        if (rst) begin
          dv[gi] <= 1'b0;
        end else if (en) begin
          dv[gi] <= dv[gi-1];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          dcl[gi] <= dcl[gi-1];
        end
      end
    end
  endgenerate

  // ---------------- fold into [-1/4, 1/4] turn ----------------
  logic signed [32:0] th_raw, ph_raw, th_f, ph_f;
  logic               th_flip, ph_flip;

  always_comb begin
    th_raw = $signed({{1{1'b0}}, 32'h4000_0000}) - $signed(ring_lane[NS].ang);
    th_raw = {th_raw[31], th_raw[31:0]};
    ph_raw = {seg_lane[NS].ang[31], seg_lane[NS].ang[31:0]};
    th_flip = 1'b0;
    ph_flip = 1'b0;
    th_f = th_raw;
    ph_f = ph_raw;
    if (th_raw > 33'sh0_4000_0000) begin
      th_f = th_raw - 33'sh0_8000_0000; th_flip = 1'b1;
    end else if (th_raw < -33'sh0_4000_0000) begin
      th_f = th_raw + 33'sh0_8000_0000; th_flip = 1'b1;
    end
    if (ph_raw > 33'sh0_4000_0000) begin
      ph_f = ph_raw - 33'sh0_8000_0000; ph_flip = 1'b1;
    end else if (ph_raw < -33'sh0_4000_0000) begin
      ph_f = ph_raw + 33'sh0_8000_0000; ph_flip = 1'b1;
    end
  end

  uvs_pkg::rot_t th_rot [0:ANGLE_STAGES];
  uvs_pkg::rot_t ph_rot [0:ANGLE_STAGES];
  uvs_pkg::meta_t cm [0:ANGLE_STAGES];
  logic          cv [0:ANGLE_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (en) begin
      cv[0] <= dv[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      th_rot[0].x <= uvs_pkg::CORDIC_K;
      th_rot[0].y <= 33'sd0;
      th_rot[0].a <= th_f;
      ph_rot[0].x <= uvs_pkg::CORDIC_K;
      ph_rot[0].y <= 33'sd0;
      ph_rot[0].a <= ph_f;
      cm[0].clamped <= dcl[NS];
      cm[0].tex_u   <= seg_lane[NS].tex;
      cm[0].tex_v   <= ring_lane[NS].tex;
      cm[0].flip_t  <= th_flip;
      cm[0].flip_p  <= ph_flip;
    end
  end

  // ---------------- CORDIC chain ----------------
  generate
    for (gi = 0; gi < ANGLE_STAGES; gi++) begin : g_cordic
      uvs_cordic_cell #(.STAGE(gi)) u_th (
        .clk(clk), .en(en), .rot_in(th_rot[gi]), .rot_out(th_rot[gi+1])
      );
      uvs_cordic_cell #(.STAGE(gi)) u_ph (
        .clk(clk), .en(en), .rot_in(ph_rot[gi]), .rot_out(ph_rot[gi+1])
      );
      always_ff @(posedge clk) begin
        if (rst) begin
          cv[gi+1] <= 1'b0;
        end else if (en) begin
          cv[gi+1] <= cv[gi];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          cm[gi+1] <= cm[gi];
        end
      end
    end
  endgenerate

  // ---------------- direction products ----------------
  logic signed [32:0] ct33, st33, cp33, sp33;
  logic signed [31:0] ct, st, cp, sp;

  always_comb begin
    ct33 = cm[ANGLE_STAGES].flip_t ? -th_rot[ANGLE_STAGES].x : th_rot[ANGLE_STAGES].x;
    st33 = cm[ANGLE_STAGES].flip_t ? -th_rot[ANGLE_STAGES].y : th_rot[ANGLE_STAGES].y;
    cp33 = cm[ANGLE_STAGES].flip_p ? -ph_rot[ANGLE_STAGES].x : ph_rot[ANGLE_STAGES].x;
    sp33 = cm[ANGLE_STAGES].flip_p ? -ph_rot[ANGLE_STAGES].y : ph_rot[ANGLE_STAGES].y;
    // all magnitudes stay near 2^30, well inside 32 bits
    ct = ct33[31:0];
    st = st33[31:0];
    cp = cp33[31:0];
    sp = sp33[31:0];
  end

  logic               p1v, p2v, p3v;
  uvs_pkg::meta_t     p1m, p2m, p3m;
  logic signed [63:0] ctcp, ctsp;
  logic signed [31:0] p1_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1v <= 1'b0;
      p2v <= 1'b0;
      p3v <= 1'b0;
    end else if (en) begin
      p1v <= cv[ANGLE_STAGES];
      p2v <= p1v;
      p3v <= p2v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctcp  <= ct * cp;
      ctsp  <= ct * sp;
      p1_st <= st;
      p1m   <= cm[ANGLE_STAGES];
    end
  end

  // ---------------- Q60 -> Q30 direction ----------------
  logic signed [63:0] rx64, ry64;
  logic signed [31:0] dir [0:2];

  always_comb begin
    rx64 = (ctcp + 64'sd536870912) >>> 30;
    ry64 = (ctsp + 64'sd536870912) >>> 30;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dir[0] <= rx64[31:0];
      dir[1] <= ry64[31:0];
      dir[2] <= p1_st;
      p2m    <= p1m;
    end
  end

  // ---------------- scale by radius, round normal ----------------
  logic signed [48:0] prod [0:2];
  logic signed [15:0] norm [0:2];
  logic signed [32:0] nsum [0:2];
  logic signed [17:0] nq   [0:2];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nsum[k] = 33'(dir[k]) + 33'sd16384;
      nq[k]   = 18'(nsum[k] >>> 15);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        prod[k] <= $signed({1'b0, radius}) * dir[k];
        norm[k] <= (nq[k] > 18'sd32767) ? 16'sh7FFF :
                   (nq[k] < -18'sd32768) ? 16'sh8000 : nq[k][15:0];
      end
      p3m <= p2m;
    end
  end

  // ---------------- Q8.8 position, result packing ----------------
  logic signed [49:0] psum [0:2];
  logic signed [19:0] pq   [0:2];
  logic [16:0]        pos  [0:2];
  logic [135:0]       res_data;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      psum[k] = 50'(prod[k]) + 50'sd536870912;
      pq[k]   = 20'(psum[k] >>> 30);
      pos[k]  = (pq[k] > 20'sd65535) ? 17'h0FFFF :
                (pq[k] < -20'sd65535) ? 17'h10001 : pq[k][16:0];
    end
    res_data = {3'b000, p3m.tex_v, p3m.tex_u, norm[2], norm[1], norm[0],
                pos[2], pos[1], pos[0]};
  end

  // ---------------- output register and skid ----------------
  logic [135:0] skid_data;
  logic         skid_user;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (skid_valid) begin
      if (m_axis_tready) begin
        skid_valid <= 1'b0;
      end
    end else if (p3v) begin
      if (!m_axis_tvalid || m_axis_tready) begin
        m_axis_tvalid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_axis_tready) begin
        m_axis_tdata <= skid_data;
        m_axis_tuser <= skid_user;
      end
    end else if (p3v) begin
      if (!m_axis_tvalid || m_axis_tready) begin
        m_axis_tdata <= res_data;
        m_axis_tuser <= p3m.clamped;
      end else begin
        skid_data <= res_data;
        skid_user <= p3m.clamped;
      end
    end
  end

  // ---------------- checks ----------------
  `UVS_ASSERT_IMP(a_skid_behind_out, skid_valid, m_axis_tvalid)
  `UVS_ASSERT_NXT(a_skid_holds, skid_valid && !m_axis_tready, skid_valid)
  `UVS_ASSERT_IMP(a_tex_u_range, m_axis_tvalid, m_axis_tdata[115:99] <= 17'h10000)
  `UVS_ASSERT_IMP(a_pos_x_sat, m_axis_tvalid, m_axis_tdata[16:0] != 17'h10000)

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the UV sphere vertex generator.
`timescale 1ns / 1ps
module testbench;

  localparam int LATENCY = 37 + uvs_pkg::ANGLE_STAGES_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [10:0] ring;
    logic [10:0] seg;
  } grid_pt_t;

  typedef struct packed {
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic signed [16:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic               clamped;
  } vertex_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [23:0]  s_axis_tdata = '0;   // ring_index[10:0], segment_index[21:11]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;        // pos_x..pos_z, norm_x..norm_z, tex_u, tex_v
  logic         m_axis_tuser;        // index_clamped
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = uvs_pkg::REG_RADIUS;
  logic [15:0]  cfg_data = '0;

  // predictor's copy of the registers
  logic [15:0] radius_q = uvs_pkg::RADIUS_RST;
  logic [10:0] segs_q = uvs_pkg::SEGS_RST;
  logic [10:0] rings_q = uvs_pkg::RINGS_RST;

  grid_pt_t pending_pts[$];
  vertex_t  expected_vertices[$];
  int       errors = 0;
  int       stall_cycles = 0;
  bit       calm = 1'b0;       // no idling near the end of the run
  int       src_gap = 0;
  int       sink_gap = 0;

  uv_sphere_vertex_generator DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // floor shift on signed 64-bit values
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint strips(logic [10:0] c);
    if (c == 0) return 1;
    if (c > uvs_pkg::MAX_STRIPS) return uvs_pkg::MAX_STRIPS;
    return c;
  endfunction

  // CORDIC sine/cosine, angle in 2^-32 turn, result Q30
  task automatic sin_cos(input longint ang, output longint co, output longint si);
    longint a, x, y, dx, dy;
    bit flip;
    a = longint'(ang[31:0]);
    if (a >= 64'sd2147483648) a -= 64'sd4294967296;
    flip = 1'b0;
    x = 652032874;
    y = 0;
    if (a > 64'sd1073741824) begin
      a -= 64'sd2147483648; flip = 1'b1;
    end else if (a < -64'sd1073741824) begin
      a += 64'sd2147483648; flip = 1'b1;
    end
    for (int i = 0; i < uvs_pkg::ANGLE_STAGES_DEF; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (a >= 0) begin
        x -= dx; y += dy; a -= longint'(uvs_pkg::atan_turn(i));
      end else begin
        x += dx; y -= dy; a += longint'(uvs_pkg::atan_turn(i));
      end
    end
    co = flip ? -x : x;
    si = flip ? -y : y;
  endtask

  task automatic predict_vertex(input grid_pt_t p, output vertex_t v);
    longint segs, rings, ring, seg, theta, phi, ct, st, cp, sp, r;
    longint dir[3], pos[3], nrm[3];
    segs = strips(segs_q);
    rings = strips(rings_q);
    ring = p.ring;
    seg = p.seg;
    v.clamped = 1'b0;
    if (ring > rings) begin
      ring = rings; v.clamped = 1'b1;
    end
    if (seg > segs) begin
      seg = segs; v.clamped = 1'b1;
    end
    phi = ((seg << 32) + segs / 2) / segs;
    theta = 64'sd1073741824 - ((ring << 31) + rings / 2) / rings;
    sin_cos(theta, ct, st);
    sin_cos(phi, cp, sp);
    dir[0] = floor_shr(ct * cp + (64'sd1 << 29), 30);
    dir[1] = floor_shr(ct * sp + (64'sd1 << 29), 30);
    dir[2] = st;
    r = radius_q;
    for (int k = 0; k < 3; k++) begin
      pos[k] = clip(floor_shr(r * dir[k] + (64'sd1 << 29), 30), -65535, 65535);
      nrm[k] = clip(floor_shr(dir[k] + (64'sd1 << 14), 15), -32768, 32767);
    end
    v.pos_x = pos[0][16:0];
    v.pos_y = pos[1][16:0];
    v.pos_z = pos[2][16:0];
    v.norm_x = nrm[0][15:0];
    v.norm_y = nrm[1][15:0];
    v.norm_z = nrm[2][15:0];
    v.tex_u = 17'(((seg << 16) + segs / 2) / segs);
    v.tex_v = 17'(((ring << 16) + rings / 2) / rings);
  endtask

  // write one register; only called while the pipeline is empty
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      uvs_pkg::REG_RADIUS: radius_q = val;
      uvs_pkg::REG_SEGS:   segs_q = val[10:0];
      uvs_pkg::REG_RINGS:  rings_q = val[10:0];
      default: ;
    endcase
  endtask

  task automatic drain_pipe();
    wait (pending_pts.size() == 0 && expected_vertices.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic add_pt(input int ring, input int seg);
    grid_pt_t p;
    p.ring = ring[10:0];
    p.seg = seg[10:0];
    pending_pts = {pending_pts, p};
  endtask

  // mostly in-range points, some past the counts, some raw 11-bit noise
  task automatic add_random(input int n);
    int rings, segs, pick;
    rings = strips(rings_q);
    segs = strips(segs_q);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7)
        add_pt($urandom_range(0, rings), $urandom_range(0, segs));
      else if (pick < 9)
        add_pt($urandom_range(0, rings + 3), $urandom_range(0, segs + 3));
      else
        add_pt($urandom_range(0, 2047), $urandom_range(0, 2047));
    end
  endtask

  // driver: pops pending requests, random idle bursts
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_pts.size() > 0 && !(!calm && $urandom_range(0, 15) == 0 &&
                   (src_gap <= 0))) begin
        vertex_t v;
        predict_vertex(pending_pts[0], v);
        expected_vertices = {expected_vertices, v};
        s_axis_tdata <= {2'b00, pending_pts[0].seg, pending_pts[0].ring};
        s_axis_tvalid <= 1'b1;
        void'(pending_pts.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
        if (!calm && pending_pts.size() > 0) src_gap <= $urandom_range(1, 11);
      end
    end
  end

  // sink side back-pressure
  always @(posedge clk) begin
    if (rst || calm) begin
      m_axis_tready <= !rst;
      sink_gap <= 0;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 19) == 0) begin
      sink_gap <= $urandom_range(1, 11);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_vertices.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        vertex_t e, a;
        e = expected_vertices.pop_front();
        a.pos_x = m_axis_tdata[16:0];
        a.pos_y = m_axis_tdata[33:17];
        a.pos_z = m_axis_tdata[50:34];
        a.norm_x = m_axis_tdata[66:51];
        a.norm_y = m_axis_tdata[82:67];
        a.norm_z = m_axis_tdata[98:83];
        a.tex_u = m_axis_tdata[115:99];
        a.tex_v = m_axis_tdata[132:116];
        a.clamped = m_axis_tuser;
        if (a.pos_x !== e.pos_x) begin
          $error("pos_x exp %0d got %0d", e.pos_x, a.pos_x); errors++;
        end
        if (a.pos_y !== e.pos_y) begin
          $error("pos_y exp %0d got %0d", e.pos_y, a.pos_y); errors++;
        end
        if (a.pos_z !== e.pos_z) begin
          $error("pos_z exp %0d got %0d", e.pos_z, a.pos_z); errors++;
        end
        if (a.norm_x !== e.norm_x) begin
          $error("norm_x exp %0d got %0d", e.norm_x, a.norm_x); errors++;
        end
        if (a.norm_y !== e.norm_y) begin
          $error("norm_y exp %0d got %0d", e.norm_y, a.norm_y); errors++;
        end
        if (a.norm_z !== e.norm_z) begin
          $error("norm_z exp %0d got %0d", e.norm_z, a.norm_z); errors++;
        end
        if (a.tex_u !== e.tex_u) begin
          $error("tex_u exp %0d got %0d", e.tex_u, a.tex_u); errors++;
        end
        if (a.tex_v !== e.tex_v) begin
          $error("tex_v exp %0d got %0d", e.tex_v, a.tex_v); errors++;
        end
        if (a.clamped !== e.clamped) begin
          $error("index_clamped exp %0d got %0d", e.clamped, a.clamped); errors++;
        end
      end
    end
  end

  // watchdog: cycles with no accepted request on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("uv_sphere_vertex_generator test failed");
      $finish;
    end
  end

  initial begin
    int settings[6][3];
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: poles, equator, seam, clamping, raw extremes
    add_pt(0, 0);
    add_pt(18, 36);
    add_pt(9, 0);
    add_pt(9, 9);
    add_pt(9, 18);
    add_pt(9, 27);
    add_pt(19, 37);
    add_pt(2047, 0);
    add_pt(0, 2047);
    add_pt(1365, 682);
    add_pt(682, 1365);
    add_pt(1024, 1024);
    drain_pipe();

    // extremes of the registers: zero counts, over-max counts, zero radius
    settings = '{'{65535, 0, 0}, '{0, 2047, 2047}, '{1, 1024, 1024},
                 '{65535, 1, 1}, '{12345, 7, 3}, '{300, 1025, 1}};
    foreach (settings[s]) begin
      write_reg(uvs_pkg::REG_RADIUS, 16'(settings[s][0]));
      write_reg(uvs_pkg::REG_SEGS, 16'(settings[s][1]));
      write_reg(uvs_pkg::REG_RINGS, 16'(settings[s][2]));
      add_pt(0, 0);
      add_pt(2047, 2047);
      add_pt(1, 1);
      add_random(130);
      // sender holds off until all results are back
      drain_pipe();
    end

    write_reg(REG_UNUSED, 16'hFFFF);   // unmapped index, must be ignored
    write_reg(uvs_pkg::REG_RADIUS, 16'($urandom_range(0, 65535)));
    write_reg(uvs_pkg::REG_SEGS, 16'($urandom_range(1, 1024)));
    write_reg(uvs_pkg::REG_RINGS, 16'($urandom_range(1, 1024)));
    add_random(200);
    wait (pending_pts.size() == 0);
    calm = 1'b1;
    add_random(150);
    wait (pending_pts.size() == 0 && expected_vertices.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
    if (errors == 0)
      $display("uv_sphere_vertex_generator test passed");
    else
      $display("uv_sphere_vertex_generator test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/uvs_pkg.sv
rtl/uvs_div_cell.sv
rtl/uvs_cordic_cell.sv
rtl/uv_sphere_vertex_generator.sv
tb/sv/testbench.sv
